>>> design/bcs_pkg.sv
// Shared codes, masks and reset values for the battery contactor safety controller.
`default_nettype none

package bcs_pkg;

    // Machine state codes.
    localparam logic [2:0] ST_INIT      = 3'd0;
    localparam logic [2:0] ST_STANDBY   = 3'd1;
    localparam logic [2:0] ST_PRECHARGE = 3'd2;
    localparam logic [2:0] ST_DRIVE     = 3'd3;
    localparam logic [2:0] ST_CHARGE    = 3'd4;
    localparam logic [2:0] ST_FAULT     = 3'd5;

    // Fault mask bits.
    typedef logic [5:0] fault_t;
    localparam fault_t F_NONE              = 6'h00;
    localparam fault_t F_INTERLOCK         = 6'h01;
    localparam fault_t F_SENSOR            = 6'h02;
    localparam fault_t F_OVERVOLT          = 6'h04;
    localparam fault_t F_UNDERVOLT         = 6'h08;
    localparam fault_t F_OVERTEMP          = 6'h10;
    localparam fault_t F_PRECHARGE_TIMEOUT = 6'h20;

    // Contactor patterns: bit0 main positive, bit1 main negative, bit2 precharge.
    typedef logic [2:0] contactor_t;
    localparam contactor_t CONTACTORS_PRECHARGE = 3'b110;
    localparam contactor_t CONTACTORS_MAIN      = 3'b011;
    localparam contactor_t CONTACTORS_OPEN      = 3'b000;

    // Configuration register indexes.
    localparam logic [1:0] REG_OVERVOLT  = 2'd0;
    localparam logic [1:0] REG_UNDERVOLT = 2'd1;
    localparam logic [1:0] REG_OVERTEMP  = 2'd2;
    localparam logic [1:0] REG_PRECHARGE = 2'd3;

    // Configuration reset values.
    localparam logic [15:0]       RST_OVERVOLT_MV  = 16'd4200;
    localparam logic [15:0]       RST_UNDERVOLT_MV = 16'd2500;
    localparam logic signed [7:0] RST_OVERTEMP_C   = 8'sd60;
    localparam logic [15:0]       RST_TIMEOUT_MS   = 16'd500;

endpackage

`default_nettype wire

>>> design/battery_contactor_safety_fsm.sv
// Top level of the battery contactor safety state machine with precharge control.
//
// Each input beat is one control tick: interlock, ignition, charger pilot,
// sensor health, precharge-ready flag, pack extremes and a millisecond time.
// The block raises a fault mask (interlock open, sensor offline, over- and
// undervoltage, overtemperature); any fault outside FAULT trips the machine to
// FAULT with all contactors open, and FAULT holds until reset. Otherwise the
// machine goes INIT to STANDBY, then on ignition to PRECHARGE (main-negative
// and precharge closed) and on to DRIVE once the bus is precharged, or to
// FAULT with the precharge-timeout bit once the elapsed time exceeds the
// limit; the charger pilot leads from STANDBY to CHARGE. Every tick yields
// exactly one result beat carrying state, contactor drive, the reported
// relay mask and the fault report, which lags a sensed-fault trip by one beat.
// A tick is captured in an input register, evaluated by one level of
// comparators and next-state logic, and moves on into the result register
// once that register is empty or being taken. One tick is taken per
// clock cycle; the only thing that holds the input off is a full input
// register behind a result that the consumer is stalling. Configuration
// writes are always ready and take effect on the next cycle.
`default_nettype none

module battery_contactor_safety_fsm
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    // Configuration write channel.
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,

    // Tick input channel.
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               interlock_closed,
    input  wire logic               ignition_on,
    input  wire logic               charge_pilot,
    input  wire logic               sensor_ok,
    input  wire logic               bus_precharged,
    input  wire logic [15:0]        max_cell_mv,
    input  wire logic [15:0]        min_cell_mv,
    input  wire logic signed [7:0]  max_temp,
    input  wire logic [31:0]        time_ms,

    // Result channel.
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [2:0]              fsm_state,
    output logic [2:0]              contactor_drive,
    output logic [2:0]              relay_status,
    output logic [5:0]              fault_report
);

    // ------------------------------------------------------------------
    // Configuration registers. The port never pushes back.
    // ------------------------------------------------------------------
    logic [15:0]       ov_limit_reg;
    logic [15:0]       uv_limit_reg;
    logic signed [7:0] ot_limit_reg;
    logic [15:0]       timeout_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_limit_reg <= bcs_pkg::RST_OVERVOLT_MV;
            uv_limit_reg <= bcs_pkg::RST_UNDERVOLT_MV;
            ot_limit_reg <= bcs_pkg::RST_OVERTEMP_C;
            timeout_reg  <= bcs_pkg::RST_TIMEOUT_MS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                bcs_pkg::REG_OVERVOLT:  ov_limit_reg <= cfg_data;
                bcs_pkg::REG_UNDERVOLT: uv_limit_reg <= cfg_data;
                bcs_pkg::REG_OVERTEMP:  ot_limit_reg <= cfg_data[7:0];
                bcs_pkg::REG_PRECHARGE: timeout_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake. The result register advances whenever it is empty or
    // being taken; the input register refills whenever it is empty or
    // moving on, so a tick can enter while a finished result waits.
    // ------------------------------------------------------------------
    logic in_valid_reg;
    logic out_valid_reg;
    logic advance;
    logic step;
    logic in_take;

    assign advance  = !out_valid_reg || !out_stall;
    assign step     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Input register: payload only, qualified by in_valid_reg.
    logic              interlock_reg;
    logic              ignition_reg;
    logic              pilot_reg;
    logic              sensor_reg;
    logic              ready_reg;
    logic [15:0]       max_mv_reg;
    logic [15:0]       min_mv_reg;
    logic signed [7:0] temp_reg;
    logic [31:0]       now_reg;

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            interlock_reg <= interlock_closed;
            ignition_reg  <= ignition_on;
            pilot_reg     <= charge_pilot;
            sensor_reg    <= sensor_ok;
            ready_reg     <= bus_precharged;
            max_mv_reg    <= max_cell_mv;
            min_mv_reg    <= min_cell_mv;
            temp_reg      <= max_temp;
            now_reg       <= time_ms;
        end
    end

    // ------------------------------------------------------------------
    // Tick evaluation: fault mask, precharge timer and next state.
    // ------------------------------------------------------------------
    logic [2:0]          mode_reg;
    logic [2:0]          mode_next;
    logic [31:0]         entry_time_reg;
    logic [31:0]         entry_time_next;
    bcs_pkg::contactor_t drive_bits_reg;
    bcs_pkg::contactor_t drive_bits_next;
    bcs_pkg::contactor_t relay_mask_reg;
    bcs_pkg::contactor_t relay_mask_next;
    bcs_pkg::fault_t     reported_reg;
    bcs_pkg::fault_t     reported_next;
    bcs_pkg::fault_t     faults;
    bcs_pkg::fault_t     faults_all;
    logic [31:0]         elapsed;
    logic                timed_out;

    always_comb
    begin
        faults = bcs_pkg::F_NONE;
        if (!interlock_reg)
        begin
            faults = faults | bcs_pkg::F_INTERLOCK;
        end
        if (!sensor_reg)
        begin
            faults = faults | bcs_pkg::F_SENSOR;
        end
        if (max_mv_reg >= ov_limit_reg)
        begin
            faults = faults | bcs_pkg::F_OVERVOLT;
        end
        if (min_mv_reg <= uv_limit_reg)
        begin
            faults = faults | bcs_pkg::F_UNDERVOLT;
        end
        if (temp_reg >= ot_limit_reg)
        begin
            faults = faults | bcs_pkg::F_OVERTEMP;
        end
    end

    // Elapsed time wraps with the free-running millisecond counter.
    assign elapsed   = now_reg - entry_time_reg;
    assign timed_out = elapsed > {16'd0, timeout_reg};

    always_comb
    begin
        mode_next       = mode_reg;
        entry_time_next = entry_time_reg;
        drive_bits_next = drive_bits_reg;
        relay_mask_next = relay_mask_reg;
        reported_next   = reported_reg;
        faults_all      = faults;

        if ((faults != bcs_pkg::F_NONE) && (mode_reg != bcs_pkg::ST_FAULT))
        begin
            // Trip tick: relay mask and fault report keep their old values,
            // so the report shows the cause one beat later.
            mode_next       = bcs_pkg::ST_FAULT;
            entry_time_next = now_reg;
            drive_bits_next = bcs_pkg::CONTACTORS_OPEN;
        end
        else
        begin
            unique case (mode_reg)
                bcs_pkg::ST_INIT:
                begin
                    mode_next       = bcs_pkg::ST_STANDBY;
                    entry_time_next = now_reg;
                    drive_bits_next = bcs_pkg::CONTACTORS_OPEN;
                end
                bcs_pkg::ST_STANDBY:
                begin
                    drive_bits_next = bcs_pkg::CONTACTORS_OPEN;
                    if (ignition_reg)
                    begin
                        mode_next       = bcs_pkg::ST_PRECHARGE;
                        entry_time_next = now_reg;
                        drive_bits_next = bcs_pkg::CONTACTORS_PRECHARGE;
                        relay_mask_next = bcs_pkg::CONTACTORS_PRECHARGE;
                    end
                    else if (pilot_reg)
                    begin
                        mode_next       = bcs_pkg::ST_CHARGE;
                        entry_time_next = now_reg;
                    end
                end
                bcs_pkg::ST_PRECHARGE:
                begin
                    if (ready_reg)
                    begin
                        mode_next       = bcs_pkg::ST_DRIVE;
                        entry_time_next = now_reg;
                        drive_bits_next = bcs_pkg::CONTACTORS_MAIN;
                        relay_mask_next = bcs_pkg::CONTACTORS_MAIN;
                    end
                    else if (timed_out)
                    begin
                        // The entry time is left as it was on a timeout.
                        faults_all      = faults | bcs_pkg::F_PRECHARGE_TIMEOUT;
                        mode_next       = bcs_pkg::ST_FAULT;
                        drive_bits_next = bcs_pkg::CONTACTORS_OPEN;
                    end
                end
                bcs_pkg::ST_DRIVE:
                begin
                    if (!ignition_reg)
                    begin
                        mode_next       = bcs_pkg::ST_STANDBY;
                        drive_bits_next = bcs_pkg::CONTACTORS_OPEN;
                        relay_mask_next = bcs_pkg::CONTACTORS_OPEN;
                    end
                end
                bcs_pkg::ST_CHARGE:
                begin
                    if (!pilot_reg)
                    begin
                        mode_next       = bcs_pkg::ST_STANDBY;
                        drive_bits_next = bcs_pkg::CONTACTORS_OPEN;
                        relay_mask_next = bcs_pkg::CONTACTORS_OPEN;
                    end
                end
                bcs_pkg::ST_FAULT:
                begin
                    drive_bits_next = bcs_pkg::CONTACTORS_OPEN;
                    relay_mask_next = bcs_pkg::CONTACTORS_OPEN;
                end
                default:
                begin
                    // Unused codes make no transition.
                end
            endcase
            reported_next = faults_all;
        end
    end

    // Machine state updates once per evaluated tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= bcs_pkg::ST_INIT;
            entry_time_reg <= 32'd0;
            drive_bits_reg <= bcs_pkg::CONTACTORS_OPEN;
            relay_mask_reg <= bcs_pkg::CONTACTORS_OPEN;
            reported_reg   <= bcs_pkg::F_NONE;
        end
        else if (step)
        begin
            mode_reg       <= mode_next;
            entry_time_reg <= entry_time_next;
            drive_bits_reg <= drive_bits_next;
            relay_mask_reg <= relay_mask_next;
            reported_reg   <= reported_next;
        end
    end

    // Result register: the new state is the result of the tick.
    logic [2:0]          state_out_reg;
    bcs_pkg::contactor_t drive_out_reg;
    bcs_pkg::contactor_t relay_out_reg;
    bcs_pkg::fault_t     fault_out_reg;

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            state_out_reg <= mode_next;
            drive_out_reg <= drive_bits_next;
            relay_out_reg <= relay_mask_next;
            fault_out_reg <= reported_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign fsm_state       = state_out_reg;
    assign contactor_drive = drive_out_reg;
    assign relay_status    = relay_out_reg;
    assign fault_report    = fault_out_reg;

endmodule

`default_nettype wire

>>> design/bcs_checker.sv
// Port-level checker for the battery contactor safety controller, with its bind.
`default_nettype none

module bcs_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [2:0] fsm_state,
    input wire logic [2:0] contactor_drive
);

    // A result in FAULT never drives a contactor.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (fsm_state == bcs_pkg::ST_FAULT)
        |-> (contactor_drive == bcs_pkg::CONTACTORS_OPEN))
        else $error("contactor closed in fault state");

    // While precharging, exactly main-negative and precharge are closed.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (fsm_state == bcs_pkg::ST_PRECHARGE)
        |-> (contactor_drive == bcs_pkg::CONTACTORS_PRECHARGE))
        else $error("wrong contactor pattern in precharge");

    // Standby and charge leave every contactor open; drive closes the mains.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((fsm_state == bcs_pkg::ST_STANDBY) || (fsm_state == bcs_pkg::ST_CHARGE))
        |-> (contactor_drive == bcs_pkg::CONTACTORS_OPEN))
        else $error("contactor closed in standby or charge");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (fsm_state == bcs_pkg::ST_DRIVE)
        |-> (contactor_drive == bcs_pkg::CONTACTORS_MAIN))
        else $error("wrong contactor pattern in drive");

    // A stalled result beat holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall
        |=> out_valid && $stable(fsm_state) && $stable(contactor_drive))
        else $error("stalled result beat changed");

endmodule

bind battery_contactor_safety_fsm bcs_checker u_bcs_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .fsm_state       (fsm_state),
    .contactor_drive (contactor_drive)
);

`default_nettype wire

>>> test/battery_contactor_safety_fsm_test.sv
// Self-checking testbench for the battery contactor safety state machine.
`timescale 1ns / 100ps

module battery_contactor_safety_fsm_test;

    import bcs_pkg::*;

    // The clock period is 4 ns. The watchdog allows far more time than the slowest
    // legal run needs: about 1100 beats, each with sender gaps, receiver stalls and
    // a pass through the input and result registers.
    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 8;
    localparam int LATENCY_SETTLE = 4;
    localparam int FINAL_SETTLE   = 8;
    localparam int IDLE_PERCENT   = 18;
    localparam int REPORT_LIMIT   = 10;
    localparam int WATCHDOG_NS    = 2_000_000;

    // One control tick, which is the payload of the input channel.
    typedef struct packed {
        logic        interlock_closed;
        logic        ignition_on;
        logic        charge_pilot;
        logic        sensor_ok;
        logic        bus_precharged;
        logic [15:0] max_cell_mv;
        logic [15:0] min_cell_mv;
        logic [7:0]  max_temp;
        logic [31:0] time_ms;
    } tick_t;

    // One status beat, which is the payload of the result channel.
    typedef struct packed {
        logic [2:0] state;
        contactor_t drive;
        contactor_t relay;
        fault_t     faults;
    } status_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;

    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = REG_OVERVOLT;
    logic [15:0]        cfg_data = 16'h0000;

    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               interlock_closed = 1'b0;
    logic               ignition_on = 1'b0;
    logic               charge_pilot = 1'b0;
    logic               sensor_ok = 1'b0;
    logic               bus_precharged = 1'b0;
    logic [15:0]        max_cell_mv = 16'h0000;
    logic [15:0]        min_cell_mv = 16'h0000;
    logic signed [7:0]  max_temp = 8'sd0;
    logic [31:0]        time_ms = 32'h0000_0000;

    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [2:0]         fsm_state;
    logic [2:0]         contactor_drive;
    logic [2:0]         relay_status;
    logic [5:0]         fault_report;

    // Random idling on both channels is switched off for one long stretch.
    logic               idle_on = 1'b1;

    // Limits as the block holds them, mirrored at every register write.
    logic [15:0]        lim_overvolt_mv  = RST_OVERVOLT_MV;
    logic [15:0]        lim_undervolt_mv = RST_UNDERVOLT_MV;
    logic [7:0]         lim_overtemp_c   = RST_OVERTEMP_C;
    logic [15:0]        lim_precharge_ms = RST_TIMEOUT_MS;

    // Mirror of the controller state after every accepted tick.
    logic [2:0]         pm_mode     = ST_INIT;
    logic [31:0]        pm_entry_ms = 32'h0000_0000;
    contactor_t         pm_drive    = CONTACTORS_OPEN;
    contactor_t         pm_relay    = CONTACTORS_OPEN;
    fault_t             pm_faults   = F_NONE;

    // Status beats that the block still owes, oldest first.
    status_t            expected_status[$];

    // Running millisecond time used when generating ticks.
    logic [31:0]        clock_ms = 32'h0000_0000;

    int                 mismatch_count = 0;
    int                 status_beats = 0;
    int                 ticks_sent = 0;
    int                 regs_written = 0;
    int                 settings_used = 0;
    int                 precharge_entries = 0;
    int                 drive_entries = 0;
    int                 charge_entries = 0;
    logic               trip_by_timeout = 1'b0;

    battery_contactor_safety_fsm u_dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .interlock_closed (interlock_closed),
        .ignition_on      (ignition_on),
        .charge_pilot     (charge_pilot),
        .sensor_ok        (sensor_ok),
        .bus_precharged   (bus_precharged),
        .max_cell_mv      (max_cell_mv),
        .min_cell_mv      (min_cell_mv),
        .max_temp         (max_temp),
        .time_ms          (time_ms),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .fsm_state        (fsm_state),
        .contactor_drive  (contactor_drive),
        .relay_status     (relay_status),
        .fault_report     (fault_report)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Advances the controller mirror by one tick and queues the status beat
    // that the block must produce for it.
    task automatic predict_status(input tick_t t);
        fault_t      seen;
        logic [31:0] elapsed;
        status_t     s;
        seen = F_NONE;
        if (!t.interlock_closed)
            seen |= F_INTERLOCK;
        if (!t.sensor_ok)
            seen |= F_SENSOR;
        if (t.max_cell_mv >= lim_overvolt_mv)
            seen |= F_OVERVOLT;
        if (t.min_cell_mv <= lim_undervolt_mv)
            seen |= F_UNDERVOLT;
        if ($signed(t.max_temp) >= $signed(lim_overtemp_c))
            seen |= F_OVERTEMP;
        // The elapsed precharge time wraps modulo 2^32 like the time itself.
        elapsed = t.time_ms - pm_entry_ms;

        if (seen != F_NONE && pm_mode != ST_FAULT)
        begin
            // On the trip tick the relay mask and the fault report keep their
            // old values, so the report catches up one tick later.
            pm_mode     = ST_FAULT;
            pm_entry_ms = t.time_ms;
            pm_drive    = CONTACTORS_OPEN;
        end
        else
        begin
            case (pm_mode)
                ST_INIT:
                begin
                    pm_mode     = ST_STANDBY;
                    pm_entry_ms = t.time_ms;
                    pm_drive    = CONTACTORS_OPEN;
                end
                ST_STANDBY:
                begin
                    pm_drive = CONTACTORS_OPEN;
                    // Ignition wins over the charger pilot.
                    if (t.ignition_on)
                    begin
                        pm_mode     = ST_PRECHARGE;
                        pm_entry_ms = t.time_ms;
                        pm_drive    = CONTACTORS_PRECHARGE;
                        pm_relay    = CONTACTORS_PRECHARGE;
                        precharge_entries++;
                    end
                    else if (t.charge_pilot)
                    begin
                        pm_mode     = ST_CHARGE;
                        pm_entry_ms = t.time_ms;
                        charge_entries++;
                    end
                end
                ST_PRECHARGE:
                begin
                    // A precharged bus wins over an expired timer, and the
                    // timeout leaves the entry time alone.
                    if (t.bus_precharged)
                    begin
                        pm_drive    = CONTACTORS_MAIN;
                        pm_relay    = CONTACTORS_MAIN;
                        pm_mode     = ST_DRIVE;
                        pm_entry_ms = t.time_ms;
                        drive_entries++;
                    end
                    else if (elapsed > {16'h0000, lim_precharge_ms})
                    begin
                        seen     |= F_PRECHARGE_TIMEOUT;
                        pm_mode  = ST_FAULT;
                        pm_drive = CONTACTORS_OPEN;
                    end
                end
                ST_DRIVE:
                begin
                    if (!t.ignition_on)
                    begin
                        pm_drive = CONTACTORS_OPEN;
                        pm_relay = CONTACTORS_OPEN;
                        pm_mode  = ST_STANDBY;
                    end
                end
                ST_CHARGE:
                begin
                    if (!t.charge_pilot)
                    begin
                        pm_drive = CONTACTORS_OPEN;
                        pm_relay = CONTACTORS_OPEN;
                        pm_mode  = ST_STANDBY;
                    end
                end
                ST_FAULT:
                begin
                    pm_drive = CONTACTORS_OPEN;
                    pm_relay = CONTACTORS_OPEN;
                end
                default:
                begin
                end
            endcase
            pm_faults = seen;
        end

        s.state  = pm_mode;
        s.drive  = pm_drive;
        s.relay  = pm_relay;
        s.faults = pm_faults;
        expected_status.push_back(s);
    endtask

    // Presents one tick, after a random gap, and holds it until it is accepted.
    // A valid that stays high into the next tick is never lowered in between.
    task automatic send_tick(input tick_t t);
        int gap;
        gap = 0;
        while (idle_on && $urandom_range(99) < IDLE_PERCENT)
            gap++;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid         <= 1'b1;
        interlock_closed <= t.interlock_closed;
        ignition_on      <= t.ignition_on;
        charge_pilot     <= t.charge_pilot;
        sensor_ok        <= t.sensor_ok;
        bus_precharged   <= t.bus_precharged;
        max_cell_mv      <= t.max_cell_mv;
        min_cell_mv      <= t.min_cell_mv;
        max_temp         <= t.max_temp;
        time_ms          <= t.time_ms;
        do
            @(posedge clk);
        while (in_stall);
        predict_status(t);
        ticks_sent++;
    endtask

    // Stops sending, waits until every owed status beat has arrived and then
    // lets the pipeline settle.
    task automatic wait_for_results(input int settle);
        in_valid <= 1'b0;
        while (expected_status.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (index)
            REG_OVERVOLT:  lim_overvolt_mv  = data;
            REG_UNDERVOLT: lim_undervolt_mv = data;
            REG_OVERTEMP:  lim_overtemp_c   = data[7:0];
            REG_PRECHARGE: lim_precharge_ms = data;
            default:
            begin
            end
        endcase
        regs_written++;
    endtask

    // Writes all four limits while the block is idle. The temperature limit
    // only uses the low byte, so the upper byte carries random junk.
    task automatic set_limits(input logic [15:0] ov_mv, input logic [15:0] uv_mv,
                              input logic [7:0] ot_c, input logic [15:0] timeout_ms);
        wait_for_results(LATENCY_SETTLE);
        write_reg(REG_OVERVOLT, ov_mv);
        write_reg(REG_UNDERVOLT, uv_mv);
        write_reg(REG_OVERTEMP, {8'($urandom), ot_c});
        write_reg(REG_PRECHARGE, timeout_ms);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // A tick with every reading comfortably inside the reset limits.
    function automatic tick_t calm_tick(input logic [31:0] at_ms);
        tick_t t;
        t                  = '0;
        t.interlock_closed = 1'b1;
        t.sensor_ok        = 1'b1;
        t.max_cell_mv      = 16'd3700;
        t.min_cell_mv      = 16'd3600;
        t.max_temp         = 8'd25;
        t.time_ms          = at_ms;
        return t;
    endfunction

    // A fault-free tick whose requests follow a plausible drive or charge
    // cycle from the current state. While precharging without a ready bus the
    // time never runs past the limit, so the machine does not trip.
    function automatic tick_t make_healthy_tick();
        tick_t       t;
        int unsigned ov;
        int unsigned uv;
        int          ot;
        int unsigned wait_ms;
        ov = lim_overvolt_mv;
        uv = lim_undervolt_mv;
        ot = $signed(lim_overtemp_c);
        wait_ms = lim_precharge_ms;

        t                  = '0;
        t.interlock_closed = 1'b1;
        t.sensor_ok        = 1'b1;
        // Readings land just inside the limit now and then.
        t.max_cell_mv = ($urandom_range(4) == 0) ? 16'(ov - 1) : 16'($urandom_range(ov - 1, 0));
        t.min_cell_mv = ($urandom_range(4) == 0) ? 16'(uv + 1) :
                        16'($urandom_range(65535, uv + 1));
        t.max_temp    = ($urandom_range(4) == 0) ? 8'(ot - 1) :
                        8'($urandom_range(ot + 127, 0) - 128);
        t.ignition_on    = 1'($urandom_range(1));
        t.charge_pilot   = 1'($urandom_range(1));
        t.bus_precharged = 1'($urandom_range(1));

        case ($urandom_range(19))
            0, 1:    clock_ms = $urandom;
            2:       clock_ms = 32'hFFFF_FFFF - $urandom_range(600, 0);
            default: clock_ms = clock_ms + $urandom_range(20, 1);
        endcase

        case (pm_mode)
            ST_STANDBY:
            begin
                t.ignition_on  = ($urandom_range(99) < 35);
                t.charge_pilot = ($urandom_range(2) == 0);
            end
            ST_PRECHARGE:
            begin
                t.bus_precharged = ($urandom_range(9) < 3);
                if (!t.bus_precharged)
                begin
                    if ($urandom_range(3) != 0)
                        wait_ms = $urandom_range(wait_ms, 0);
                    clock_ms = pm_entry_ms + wait_ms;
                end
                else
                    clock_ms = pm_entry_ms + $urandom_range(70000, 0);
            end
            ST_DRIVE:
                t.ignition_on = ($urandom_range(9) != 0);
            ST_CHARGE:
                t.charge_pilot = ($urandom_range(9) != 0);
            default:
            begin
            end
        endcase
        t.time_ms = clock_ms;
        return t;
    endfunction

    // Any tick at all, with readings often close to the current limits.
    function automatic tick_t make_any_tick();
        tick_t t;
        t.interlock_closed = ($urandom_range(3) != 0);
        t.ignition_on      = 1'($urandom_range(1));
        t.charge_pilot     = 1'($urandom_range(1));
        t.sensor_ok        = ($urandom_range(3) != 0);
        t.bus_precharged   = 1'($urandom_range(1));
        t.max_cell_mv      = ($urandom_range(1) == 0) ? 16'($urandom) :
                             16'(lim_overvolt_mv + $urandom_range(2) - 1);
        t.min_cell_mv      = ($urandom_range(1) == 0) ? 16'($urandom) :
                             16'(lim_undervolt_mv + $urandom_range(2) - 1);
        t.max_temp         = ($urandom_range(1) == 0) ? 8'($urandom) :
                             8'(lim_overtemp_c + $urandom_range(2) - 1);
        t.time_ms          = $urandom;
        return t;
    endfunction

    // Compares one accepted status beat with the oldest owed beat.
    task automatic check_status_beat();
        status_t want;
        status_t got;
        got.state  = fsm_state;
        got.drive  = contactor_drive;
        got.relay  = relay_status;
        got.faults = fault_report;
        status_beats++;
        if (expected_status.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("status beat %0d arrived with none owed: state %0d drive %b relay %b faults %b",
                         status_beats, got.state, got.drive, got.relay, got.faults);
        end
        else
        begin
            want = expected_status.pop_front();
            if (got.state !== want.state || got.drive !== want.drive ||
                got.relay !== want.relay || got.faults !== want.faults)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("status beat %0d: state %0d/%0d drive %b/%b relay %b/%b faults %b/%b (expected/actual)",
                             status_beats, want.state, got.state, want.drive, got.drive,
                             want.relay, got.relay, want.faults, got.faults);
            end
        end
    endtask

    // Result side: every beat taken at a clock edge is checked, and the stall
    // for the next cycle is drawn at random.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                check_status_beat();
            out_stall <= idle_on && ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    // Walks through every fault-free state and transition with the reset limits: the
    // initial step that ignores requests, readings just inside the limits,
    // precharge held exactly at the timeout, the drive and charge holds,
    // ignition winning over the pilot, and a precharge across the time wrap.
    task automatic test_power_up_sequence();
        tick_t t;
        t = calm_tick(32'd1000);
        t.ignition_on  = 1'b1;
        t.charge_pilot = 1'b1;
        send_tick(t);
        t = calm_tick(32'd1010);
        t.max_cell_mv = RST_OVERVOLT_MV - 16'd1;
        t.min_cell_mv = RST_UNDERVOLT_MV + 16'd1;
        t.max_temp    = RST_OVERTEMP_C - 8'sd1;
        send_tick(t);
        t = calm_tick(32'd1020);
        t.ignition_on = 1'b1;
        send_tick(t);
        // Exactly at the limit the timer has not yet expired.
        t = calm_tick(32'd1020 + RST_TIMEOUT_MS);
        t.ignition_on = 1'b1;
        send_tick(t);
        t = calm_tick(32'd1530);
        t.ignition_on    = 1'b1;
        t.bus_precharged = 1'b1;
        send_tick(t);
        // Drive holds; the readings sit at their healthy extremes.
        t = calm_tick(32'd1540);
        t.ignition_on  = 1'b1;
        t.charge_pilot = 1'b1;
        t.max_cell_mv  = 16'h0000;
        t.min_cell_mv  = 16'hFFFF;
        t.max_temp     = 8'h80;
        send_tick(t);
        t = calm_tick(32'd1550);
        send_tick(t);
        t = calm_tick(32'd1560);
        t.charge_pilot = 1'b1;
        send_tick(t);
        t = calm_tick(32'd1570);
        t.charge_pilot   = 1'b1;
        t.ignition_on    = 1'b1;
        t.bus_precharged = 1'b1;
        send_tick(t);
        t = calm_tick(32'd1580);
        send_tick(t);
        t = calm_tick(32'hFFFF_FF00);
        t.ignition_on  = 1'b1;
        t.charge_pilot = 1'b1;
        send_tick(t);
        // The elapsed time across the wrap equals the limit, so no timeout.
        t = calm_tick(32'h0000_00F4);
        t.ignition_on = 1'b1;
        send_tick(t);
        t = calm_tick(32'hFFFF_FFFF);
        t.ignition_on    = 1'b1;
        t.bus_precharged = 1'b1;
        send_tick(t);
        t = calm_tick(32'h0000_0000);
        send_tick(t);
        clock_ms = 32'd0;
    endtask

    // Long fault-free runs of drive and charge cycles under several limit
    // settings, the widest and the tightest among them. Faults are kept out
    // here because the lockout can only be left through reset.
    task automatic test_healthy_operation();
        repeat (200) send_tick(make_healthy_tick());

        set_limits(16'hFFFF, 16'h0000, 8'sd127, 16'h0000);
        idle_on = 1'b0;
        repeat (200) send_tick(make_healthy_tick());

        set_limits(16'($urandom_range(65535, 1)), 16'($urandom_range(65534, 0)),
                   8'($urandom_range(254, 0) - 127), 16'hFFFF);
        idle_on = 1'b1;
        repeat (200) send_tick(make_healthy_tick());

        set_limits(16'($urandom_range(65535, 1)), 16'($urandom_range(65534, 0)),
                   8'($urandom_range(254, 0) - 127), 16'($urandom));
        repeat (200) send_tick(make_healthy_tick());

        // Only one reading per field is healthy under these limits.
        set_limits(16'd1, 16'd65534, -8'sd127, 16'd1);
        repeat (100) send_tick(make_healthy_tick());
    endtask

    // Trips the lockout, either by letting precharge time out or by a sensed
    // fault from whatever state the healthy runs left behind.
    task automatic test_fault_trip();
        tick_t  t;
        fault_t inject;
        int     ot;
        trip_by_timeout = 1'($urandom_range(1));
        if (trip_by_timeout)
        begin
            while (pm_mode != ST_PRECHARGE)
            begin
                t = make_healthy_tick();
                if (pm_mode == ST_DRIVE)
                    t.ignition_on = 1'b0;
                else if (pm_mode == ST_CHARGE)
                    t.charge_pilot = 1'b0;
                else
                    t.ignition_on = 1'b1;
                send_tick(t);
            end
            t = make_healthy_tick();
            t.bus_precharged = 1'b0;
            t.time_ms = pm_entry_ms + lim_precharge_ms + 32'd1 + $urandom_range(100, 0);
            send_tick(t);
            // The next clean tick clears the report but not the lockout.
            t = make_healthy_tick();
            send_tick(t);
        end
        else
        begin
            ot     = $signed(lim_overtemp_c);
            inject = fault_t'($urandom_range(31, 1));
            t      = make_healthy_tick();
            if ((inject & F_INTERLOCK) != F_NONE)
                t.interlock_closed = 1'b0;
            if ((inject & F_SENSOR) != F_NONE)
                t.sensor_ok = 1'b0;
            if ((inject & F_OVERVOLT) != F_NONE)
                t.max_cell_mv = 16'($urandom_range(65535, lim_overvolt_mv));
            if ((inject & F_UNDERVOLT) != F_NONE)
                t.min_cell_mv = 16'($urandom_range(lim_undervolt_mv, 0));
            if ((inject & F_OVERTEMP) != F_NONE)
                t.max_temp = 8'($urandom_range(127 - ot, 0) + ot);
            send_tick(t);
            // The same faults again: only now does the report show them.
            t.time_ms = t.time_ms + 32'd1;
            send_tick(t);
        end
    endtask

    // Inside the lockout every request is ignored while the fault report
    // follows each tick, including the faulting extremes of every reading.
    task automatic test_fault_lockout();
        tick_t t;
        // Every reading faults under these limits.
        set_limits(16'h0000, 16'hFFFF, 8'h80, 16'h0000);
        repeat (40) send_tick(make_any_tick());

        set_limits(RST_OVERVOLT_MV, RST_UNDERVOLT_MV, RST_OVERTEMP_C, RST_TIMEOUT_MS);
        t = calm_tick(32'hFFFF_FFFF);
        t.max_cell_mv    = 16'hFFFF;
        t.min_cell_mv    = 16'h0000;
        t.max_temp       = 8'sd127;
        t.ignition_on    = 1'b1;
        t.charge_pilot   = 1'b1;
        t.bus_precharged = 1'b1;
        send_tick(t);
        t = calm_tick(32'h0000_0001);
        t.interlock_closed = 1'b0;
        t.sensor_ok        = 1'b0;
        t.ignition_on      = 1'b1;
        send_tick(t);
        t = calm_tick(32'h0000_0002);
        t.ignition_on = 1'b1;
        send_tick(t);
        repeat (60) send_tick(make_any_tick());

        set_limits(16'($urandom), 16'($urandom), 8'($urandom), 16'($urandom));
        repeat (60) send_tick(make_any_tick());
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_power_up_sequence();
        test_healthy_operation();
        test_fault_trip();
        test_fault_lockout();

        wait_for_results(FINAL_SETTLE);
        $display("Checked %0d status beats from %0d ticks over %0d limit settings (%0d register writes).",
                 status_beats, ticks_sent, settings_used + 1, regs_written);
        $display("Precharge entered %0d times, drive %0d, charge %0d; lockout reached by %s.",
                 precharge_entries, drive_entries, charge_entries,
                 trip_by_timeout ? "precharge timeout" : "a sensed fault");
        if (mismatch_count == 0 && expected_status.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog for a block that stops accepting ticks or producing beats.
    initial
    begin
        #(WATCHDOG_NS);
        $display("Timed out with %0d status beats still owed.", expected_status.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
